>>> rtl/arh_pkg.sv
package arh_pkg;

	localparam int NUM_BINS = 16;
	localparam int BIN_W    = $clog2(NUM_BINS);
	localparam int EXP_W    = 5;
	localparam int EXP_MAX  = 31;
	localparam int CNT_W    = 32;
	localparam int VAL_W    = 32;
	localparam int RANGE_W  = 31;
	localparam int BNUM_W   = 4;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	typedef enum logic [0:0] {
		REQ_SAMPLE  = 1'b0,
		REQ_READOUT = 1'b1
	} req_kind_t;

	typedef enum logic [1:0] {
		ST_FETCH,
		ST_DISPATCH,
		ST_RECORD,
		ST_EMIT
	} step_t;

	typedef enum logic [1:0] {
		OP_NOP,
		OP_WIDEN,
		OP_INC
	} op_t;

	typedef enum logic [1:0] {
		C_ACCEPT,
		C_READOUT,
		C_WIDEN,
		C_LAST
	} cond_t;

	typedef struct packed {
		logic  in_ready;
		logic  out_valid;
		cond_t cond;
		op_t   op_hit;
		op_t   op_miss;
		step_t tgt_hit;
		step_t tgt_miss;
	} ucode_t;

	// datapath -> sequencer
	typedef struct packed {
		logic accept;
		logic readout;
		logic widen;
		logic last_beat;
	} seq_stat_t;

	// sequencer -> datapath
	typedef struct packed {
		logic in_ready;
		logic out_valid;
		op_t  op;
	} seq_ctl_t;

	function automatic ucode_t ucode_rom(input step_t step);
		ucode_t uw;
		case (step)
			ST_FETCH:    uw = '{1'b1, 1'b0, C_ACCEPT,  OP_NOP,   OP_NOP, ST_DISPATCH, ST_FETCH};
			ST_DISPATCH: uw = '{1'b0, 1'b0, C_READOUT, OP_NOP,   OP_NOP, ST_EMIT,     ST_RECORD};
			ST_RECORD:   uw = '{1'b0, 1'b0, C_WIDEN,   OP_WIDEN, OP_INC, ST_RECORD,   ST_FETCH};
			ST_EMIT:     uw = '{1'b0, 1'b1, C_LAST,    OP_NOP,   OP_NOP, ST_FETCH,    ST_EMIT};
			default:     uw = '{1'b1, 1'b0, C_ACCEPT,  OP_NOP,   OP_NOP, ST_DISPATCH, ST_FETCH};
		endcase
		return uw;
	endfunction

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
			input logic [CNT_W-1:0] b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
	endfunction

endpackage

>>> rtl/arh_req_if.sv
interface arh_req_if;
	import arh_pkg::*;

	logic                    valid;
	logic                    ready;
	logic                    req_type;
	logic signed [VAL_W-1:0] sample_value;

	modport source(output valid, req_type, sample_value, input ready);
	modport sink(input valid, req_type, sample_value, output ready);
endinterface

>>> rtl/arh_res_if.sv
interface arh_res_if;
	import arh_pkg::*;

	logic               valid;
	logic               ready;
	logic [BNUM_W-1:0]  bin_number;
	logic [RANGE_W-1:0] range_low;
	logic [RANGE_W-1:0] range_high;
	logic [CNT_W-1:0]   bin_count;
	logic               last_bin;

	modport source(output valid, bin_number, range_low, range_high, bin_count, last_bin,
		input ready);
	modport sink(input valid, bin_number, range_low, range_high, bin_count, last_bin,
		output ready);
endinterface

>>> rtl/auto_ranging_histogram.sv
// Sample: fetch, dispatch and record steps from accept to the next accept, record
//   repeating once per width doubling; the doubling loop merges all bins at once.
// Readout: dispatch, then NUM_BINS emit beats, one per cycle without backpressure.
// One item is in flight at a time; ready is high only in the fetch step.
// arst_n clears all bin counts, the width exponent and the sequencer.
module auto_ranging_histogram (
	input logic    clk,
	input logic    arst_n,
	arh_req_if.sink   req,
	arh_res_if.source res
);
	import arh_pkg::*;

	localparam int RCW = BIN_W + EXP_MAX + 2;

	seq_stat_t stat;
	seq_ctl_t  ctl;

	logic                 type_q;
	logic [VAL_W-1:0]     val_q;
	logic [EXP_W-1:0]     exp_q;
	logic [CNT_W-1:0]     bins_q [NUM_BINS];
	logic [CNT_W-1:0]     merged [NUM_BINS];
	logic [BIN_W-1:0]     rd_q;

	logic                 neg;
	logic [VAL_W-2:0]     scaled;
	logic [BIN_W-1:0]     idx;
	logic [BIN_W-1:0]     sel_idx;
	logic [CNT_W-1:0]     rdata;
	logic                 last;
	logic                 out_fire;
	logic [RCW-1:0]       lo_full;
	logic [RCW-1:0]       hi_full;

	arh_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	assign neg    = val_q[VAL_W-1];
	assign scaled = val_q[VAL_W-2:0] >> exp_q;
	assign idx    = (scaled >= (VAL_W-1)'(NUM_BINS)) ? BIN_W'(NUM_BINS - 1)
	                                                 : scaled[BIN_W-1:0];

	// single read port shared by increment and readout
	assign sel_idx = ctl.out_valid ? rd_q : idx;
	assign rdata   = bins_q[sel_idx];

	assign last     = (rd_q == BIN_W'(NUM_BINS - 1));
	assign out_fire = res.valid && res.ready;

	assign stat.accept    = req.valid && req.ready;
	assign stat.readout   = (type_q == REQ_READOUT);
	assign stat.widen     = !neg && (exp_q != EXP_W'(EXP_MAX))
	                        && (scaled >= (VAL_W-1)'(NUM_BINS));
	assign stat.last_beat = out_fire && last;

	always_comb begin
		for (int i = 0; i < NUM_BINS; i++) begin
			merged[i] = '0;
		end
		for (int i = 0; i < NUM_BINS / 2; i++) begin
			merged[i] = sat_add(bins_q[2*i], bins_q[2*i+1]);
		end
	end

	always_ff @(posedge clk) begin
		if (stat.accept) begin
			type_q <= req.req_type;
			val_q  <= req.sample_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q <= '0;
			rd_q  <= '0;
			for (int i = 0; i < NUM_BINS; i++) begin
				bins_q[i] <= '0;
			end
		end else begin
			case (ctl.op)
				OP_WIDEN: begin
					exp_q <= exp_q + EXP_W'(1);
					for (int i = 0; i < NUM_BINS; i++) begin
						bins_q[i] <= merged[i];
					end
				end
				OP_INC: begin
					if (!neg && rdata != CNT_MAX) begin
						bins_q[idx] <= rdata + CNT_W'(1);
					end
				end
				default: begin
				end
			endcase
			if (out_fire) begin
				rd_q <= last ? '0 : rd_q + BIN_W'(1);
			end
		end
	end

	assign lo_full = RCW'(rd_q) << exp_q;
	assign hi_full = ((RCW'(rd_q) + RCW'(1)) << exp_q) - RCW'(1);

	assign req.ready      = ctl.in_ready;
	assign res.valid      = ctl.out_valid;
	assign res.bin_number = BNUM_W'(rd_q);
	assign res.range_low  = lo_full[RANGE_W-1:0];
	assign res.range_high = hi_full[RANGE_W-1:0];
	assign res.bin_count  = rdata;
	assign res.last_bin   = last;
endmodule

>>> rtl/arh_seq.sv
module arh_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  arh_pkg::seq_stat_t stat,
	output arh_pkg::seq_ctl_t  ctl
);
	import arh_pkg::*;

	step_t  step_q;
	step_t  step_nxt;
	ucode_t uw;
	logic   hit;

	assign uw = ucode_rom(step_q);

	always_comb begin
		case (uw.cond)
			C_ACCEPT:  hit = stat.accept;
			C_READOUT: hit = stat.readout;
			C_WIDEN:   hit = stat.widen;
			C_LAST:    hit = stat.last_beat;
			default:   hit = 1'b0;
		endcase
	end

	// next step
	always_comb begin
		step_nxt = hit ? uw.tgt_hit : uw.tgt_miss;
	end

	// control outputs
	always_comb begin
		ctl.in_ready  = uw.in_ready;
		ctl.out_valid = uw.out_valid;
		ctl.op        = hit ? uw.op_hit : uw.op_miss;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_FETCH;
		end else begin
			step_q <= step_nxt;
		end
	end
endmodule

>>> rtl/arh_checker.sv
module arh_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       in_type,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic                       out_last,
	input logic [arh_pkg::BNUM_W-1:0] out_bin
);
	import arh_pkg::*;

	// never both sides open at once: one item at a time
	a_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("ready and result valid high together");

	a_readout_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_type == REQ_READOUT) |-> ##2 (out_valid && out_bin == '0))
		else $error("readout did not start at bin zero");

	a_sample_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_type == REQ_SAMPLE) |=> !out_valid)
		else $error("sample produced a result");

	a_bin_step: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !out_last) |=>
			(out_valid && out_bin == $past(out_bin) + BNUM_W'(1)))
		else $error("bin number did not advance");

	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && out_last) |=> (in_ready && !out_valid))
		else $error("no return to fetch after last beat");
endmodule

bind auto_ranging_histogram arh_checker u_arh_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (req.valid),
	.in_ready  (req.ready),
	.in_type   (req.req_type),
	.out_valid (res.valid),
	.out_ready (res.ready),
	.out_last  (res.last_bin),
	.out_bin   (res.bin_number)
);
